/* hdl/incremental_pid_servo_positioner_core_macros.svh */
// assertion macros shared by the servo positioner rtl
`ifndef INCREMENTAL_PID_SERVO_POSITIONER_CORE_MACROS_SVH
`define INCREMENTAL_PID_SERVO_POSITIONER_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define IPID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define IPID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ipid_pkg.sv */
// shared types, widths and constants of the servo positioner
package ipid_pkg;

    // defaults of the top level parameters
    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int SUM_WIDTH_DEF       = 40;

    // field widths
    localparam int IN_W   = 17;
    localparam int ANG_W  = 16;
    localparam int DEG_W  = 8;
    localparam int GAIN_W = 16;
    localparam int RATE_W = 10;

    // datapath widths
    localparam int ERR_W       = 19;
    localparam int PREV_W      = 20;
    localparam int DIFF_W      = 20;
    localparam int DR_W        = 31;
    localparam int FR_W        = 32;
    localparam int INTEG_EXTRA = 16;
    localparam int DVD_W       = ERR_W - 1 + INTEG_EXTRA;
    localparam int INC_W       = DVD_W + 1;
    localparam int MUL_A_W     = 33;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 64;
    localparam int IQ_W        = 47;
    localparam int IQ_LO_W     = 24;
    localparam int FR_SHIFT    = 16;
    localparam int UPD_SHIFT   = 12;
    localparam int ANGSUM_W    = 54;
    localparam logic [63:0] IQ_LIMIT = 64'h0000_2000_0000_0000;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_PROP,
        REG_GAIN_DERIV,
        REG_GAIN_INTEG,
        REG_LOOP_RATE,
        REG_SMOOTHING,
        REG_ANGLE_MIN,
        REG_ANGLE_MAX
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_deriv;
        logic [GAIN_W-1:0] gain_integ;
        logic [RATE_W-1:0] loop_rate_hz;
        logic [GAIN_W-1:0] smoothing;
        logic [ANG_W-1:0]  angle_min;
        logic [ANG_W-1:0]  angle_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_prop:    16'd4096,
        gain_deriv:   16'd41,
        gain_integ:   16'd41,
        loop_rate_hz: 10'd100,
        smoothing:    16'd32768,
        angle_min:    16'd0,
        angle_max:    16'd46080
    };

    // accumulator operations of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_ADD_HI
    } acc_op_t;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] mul_a;
        logic signed [MUL_B_W-1:0] mul_b;
        acc_op_t                   acc_op;
    } mac_ctrl_t;

    typedef struct packed {
        logic              start;
        logic              negate;
        logic [DVD_W-1:0]  dividend;
        logic [RATE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [INC_W-1:0] quot;
    } div_stat_t;

endpackage

/* hdl/ipid_ifs.sv */
// request and result channel interfaces of the servo positioner

interface ipid_in_if;
    import ipid_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] measured_angle;
    logic signed [IN_W-1:0] beam_angle;

    modport source (output valid, measured_angle, beam_angle, input ready);
    modport sink   (input valid, measured_angle, beam_angle, output ready);
endinterface

interface ipid_out_if;
    import ipid_pkg::*;

    logic             valid;
    logic             ready;
    logic [ANG_W-1:0] drive_angle;
    logic [DEG_W-1:0] servo_degrees;
    logic             hit_upper;
    logic             hit_lower;

    modport source (output valid, drive_angle, servo_degrees, hit_upper, hit_lower,
                    input ready);
    modport sink   (input valid, drive_angle, servo_degrees, hit_upper, hit_lower,
                    output ready);
endinterface

/* hdl/ipid_cfg.sv */
// configuration register file behind the apb-style port
module ipid_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ipid_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ipid_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ipid_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ipid_pkg::cfg_t                   cfg
);
    import ipid_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GAIN_PROP:  cfg_reg.gain_prop    <= pwdata[GAIN_W-1:0];
                REG_GAIN_DERIV: cfg_reg.gain_deriv   <= pwdata[GAIN_W-1:0];
                REG_GAIN_INTEG: cfg_reg.gain_integ   <= pwdata[GAIN_W-1:0];
                REG_LOOP_RATE:  cfg_reg.loop_rate_hz <= pwdata[RATE_W-1:0];
                REG_SMOOTHING:  cfg_reg.smoothing    <= pwdata[GAIN_W-1:0];
                REG_ANGLE_MIN:  cfg_reg.angle_min    <= pwdata[ANG_W-1:0];
                REG_ANGLE_MAX:  cfg_reg.angle_max    <= pwdata[ANG_W-1:0];
                default:        cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_GAIN_PROP:  prdata = APB_DATA_W'(cfg_reg.gain_prop);
            REG_GAIN_DERIV: prdata = APB_DATA_W'(cfg_reg.gain_deriv);
            REG_GAIN_INTEG: prdata = APB_DATA_W'(cfg_reg.gain_integ);
            REG_LOOP_RATE:  prdata = APB_DATA_W'(cfg_reg.loop_rate_hz);
            REG_SMOOTHING:  prdata = APB_DATA_W'(cfg_reg.smoothing);
            REG_ANGLE_MIN:  prdata = APB_DATA_W'(cfg_reg.angle_min);
            REG_ANGLE_MAX:  prdata = APB_DATA_W'(cfg_reg.angle_max);
            default:        prdata = '0;
        endcase
    end

endmodule

/* hdl/ipid_mac.sv */
// shared multiply-accumulate unit: registered product, then wide accumulate
module ipid_mac (
    input  logic                                 clk,
    input  ipid_pkg::mac_ctrl_t                  ctrl,
    output logic signed [ipid_pkg::PROD_W-1:0]   prod,
    output logic signed [ipid_pkg::ACC_W-1:0]    acc
);
    import ipid_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(prod_reg);
    assign prod     = prod_reg;
    assign acc      = acc_reg;

    // accumulator update, high partial product lands above the low slice
    always_comb
    begin
        case (ctrl.acc_op)
            ACC_HOLD:   acc_next = acc_reg;
            ACC_CLR:    acc_next = '0;
            ACC_ADD:    acc_next = acc_reg + prod_ext;
            ACC_ADD_HI: acc_next = acc_reg + (prod_ext <<< IQ_LO_W);
            default:    acc_next = acc_reg;
        endcase
    end

    // product and accumulator registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'($signed(ctrl.mul_a)) * PROD_W'($signed(ctrl.mul_b));
        acc_reg  <= acc_next;
    end

endmodule

/* hdl/ipid_div.sv */
// restoring divider, one quotient bit per cycle, signed result
module ipid_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ipid_pkg::div_req_t   req,
    output ipid_pkg::div_stat_t  stat
);
    import ipid_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0]  count_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [DVD_W-1:0]  work_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] dsr_reg;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   trial_diff;
    logic              take;
    logic signed [INC_W-1:0] quot_mag;

    // one restoring step
    assign trial      = {rem_reg, work_reg[DVD_W-1]};
    assign trial_diff = trial - {1'b0, dsr_reg};
    assign take       = (trial >= {1'b0, dsr_reg});

    // step counter and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (req.start)
        begin
            count_reg <= CNT_W'(DVD_W);
            done_reg  <= 1'b0;
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // dividend shifts out, quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            work_reg <= req.dividend;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
            neg_reg  <= req.negate;
        end
        else if (count_reg != '0)
        begin
            work_reg <= {work_reg[DVD_W-2:0], take};
            rem_reg  <= take ? trial_diff[RATE_W-1:0] : trial[RATE_W-1:0];
        end
    end

    // truncation toward zero: divide magnitudes, restore sign
    assign quot_mag  = $signed({1'b0, work_reg});
    assign stat.done = done_reg;
    assign stat.quot = neg_reg ? -quot_mag : quot_mag;

endmodule

/* hdl/incremental_pid_servo_positioner_core.sv */
// top level of the incremental pid servo positioner
//
// usage
//   sample: valid/ready request channel carrying measured_angle and beam_angle
//     (signed degrees, 8 fraction bits). result: valid/ready channel carrying
//     drive_angle, servo_degrees and the two clamp flags, one result per request.
//   apb-style port: seven registers at byte address 4*i, written in the access
//     phase, pready tied high; write them only while the block is idle.
// timing
//   sample.ready is high only while the sequencer is idle. after acceptance the sequencer
//   registers the error and then its difference, waits out the 34 divider steps of the
//   integral increment, picks up the quotient, then forms the integral term, update and
//   clamp. the shared multiply-accumulate unit finishes the derivative and proportional
//   terms in eight steps while the divider runs. a new request is taken only once the
//   previous result has been loaded into the output register.
// reset
//   rst_n clears the servo angle, previous error, filtered rate and integral,
//   and reloads the register defaults.
// back pressure
//   the result sits in an output register; the next request is taken meanwhile and
//   the sequencer waits at its last step until that register is free.
`include "incremental_pid_servo_positioner_core_macros.svh"

module incremental_pid_servo_positioner_core #(
    parameter int ANGLE_FRAC_BITS = ipid_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int SUM_WIDTH       = ipid_pkg::SUM_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ipid_in_if.sink                          sample,
    ipid_out_if.source                       result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ipid_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ipid_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ipid_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ipid_pkg::*;

    localparam int SAT_W = ((SUM_WIDTH > INC_W) ? SUM_WIDTH : INC_W) + 1;
    localparam int EXT_W = (SUM_WIDTH > 48) ? SUM_WIDTH : 48;
    localparam logic signed [SAT_W-1:0] SUM_MAX =
        {{(SAT_W - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SUM_MIN = ~SUM_MAX;
    localparam logic signed [ACC_W-1:0] FR_MAX =
        {{(ACC_W - FR_W + 1){1'b0}}, {(FR_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] FR_MIN = ~FR_MAX;
    localparam logic signed [EXT_W-1:0] IQ_MAX = EXT_W'(IQ_LIMIT);
    localparam logic signed [EXT_W-1:0] IQ_MIN = -IQ_MAX;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_M_DR,
        ST_M_SMFR,
        ST_M_WDR,
        ST_D_ACC,
        ST_D_FR,
        ST_M_KP,
        ST_M_KD,
        ST_KD_ADD,
        ST_WAIT_DIV,
        ST_INTEG,
        ST_IQ,
        ST_M_KIL,
        ST_M_KIH,
        ST_KIH_ADD,
        ST_UPD,
        ST_CLAMP
    } state_t;

    state_t state_reg;

    cfg_t      cfg;
    mac_ctrl_t mac_ctrl;
    div_req_t  div_req;
    div_stat_t div_stat;
    logic signed [PROD_W-1:0] mac_prod;
    logic signed [ACC_W-1:0]  mac_acc;

    // loop state
    logic [ANG_W-1:0]            ang_reg;
    logic signed [PREV_W-1:0]    prev_reg;
    logic signed [FR_W-1:0]      fr_reg;
    logic signed [SUM_WIDTH-1:0] es_reg;

    // per-request working registers
    logic signed [IN_W-1:0]     meas_reg;
    logic signed [IN_W-1:0]     targ_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [DR_W-1:0]     dr_reg;
    logic signed [INC_W-1:0]    inc_reg;
    logic signed [IQ_W-1:0]     iq_reg;
    logic signed [ANGSUM_W-1:0] sum_reg;

    // output registers
    logic             out_valid_reg;
    logic [ANG_W-1:0] out_angle_reg;
    logic [DEG_W-1:0] out_deg_reg;
    logic             out_up_reg;
    logic             out_lo_reg;

    // combinational helpers
    logic [RATE_W-1:0]          rate_eff;
    logic signed [ERR_W-1:0]    err_next;
    logic signed [ERR_W-1:0]    err_mag;
    logic signed [DIFF_W-1:0]   diff_next;
    logic signed [ACC_W-1:0]    acc_fr;
    logic signed [FR_W-1:0]     fr_next;
    logic signed [SAT_W-1:0]    es_sum;
    logic signed [SUM_WIDTH-1:0] es_next;
    logic signed [SUM_WIDTH-1:0] es_shift;
    logic signed [EXT_W-1:0]    es_ext;
    logic signed [IQ_W-1:0]     iq_next;
    logic signed [ACC_W-1:0]    acc_upd;
    logic signed [ANGSUM_W-1:0] sum_next;
    logic signed [ANGSUM_W-1:0] max_ext;
    logic signed [ANGSUM_W-1:0] min_ext;
    logic [ANG_W-1:0]           ang_next;
    logic                       hit_up;
    logic                       hit_lo;
    logic                       out_load;

    ipid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipid_mac u_mac (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    ipid_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // a zero rate acts as one
    assign rate_eff = (cfg.loop_rate_hz == '0) ? RATE_W'(1) : cfg.loop_rate_hz;

    // error and its difference
    assign err_next  = ERR_W'(targ_reg) - (ERR_W'(ang_reg) + ERR_W'(meas_reg));
    assign err_mag   = err_reg[ERR_W-1] ? -err_reg : err_reg;
    assign diff_next = DIFF_W'(err_reg) - prev_reg;

    // divider request: (error << 16) / rate
    assign div_req.start    = (state_reg == ST_DIFF);
    assign div_req.negate   = err_reg[ERR_W-1];
    assign div_req.dividend = {err_mag[ERR_W-2:0], {INTEG_EXTRA{1'b0}}};
    assign div_req.divisor  = rate_eff;

    // filtered rate: floor shift and saturate to 32 bits
    assign acc_fr  = mac_acc >>> FR_SHIFT;
    assign fr_next = (acc_fr > FR_MAX) ? FR_W'(FR_MAX)
                   : (acc_fr < FR_MIN) ? FR_W'(FR_MIN)
                   : FR_W'(acc_fr);

    // saturating integral update
    assign es_sum  = SAT_W'(es_reg) + SAT_W'(inc_reg);
    assign es_next = (es_sum > SUM_MAX) ? SUM_WIDTH'(SUM_MAX)
                   : (es_sum < SUM_MIN) ? SUM_WIDTH'(SUM_MIN)
                   : SUM_WIDTH'(es_sum);

    // integral term operand, clamped
    assign es_shift = es_reg >>> INTEG_EXTRA;
    assign es_ext   = EXT_W'(es_shift);
    assign iq_next  = (es_ext > IQ_MAX) ? IQ_W'(IQ_MAX)
                    : (es_ext < IQ_MIN) ? IQ_W'(IQ_MIN)
                    : IQ_W'(es_ext);

    // new unclamped angle
    assign acc_upd  = mac_acc >>> UPD_SHIFT;
    assign sum_next = ANGSUM_W'(acc_upd) + ANGSUM_W'({1'b0, ang_reg});
    assign max_ext  = ANGSUM_W'({1'b0, cfg.angle_max});
    assign min_ext  = ANGSUM_W'({1'b0, cfg.angle_min});

    // clamp, upper limit tested first
    always_comb
    begin
        hit_up   = 1'b0;
        hit_lo   = 1'b0;
        ang_next = sum_reg[ANG_W-1:0];
        if (sum_reg > max_ext)
        begin
            ang_next = cfg.angle_max;
            hit_up   = 1'b1;
        end
        else if (sum_reg < min_ext)
        begin
            ang_next = cfg.angle_min;
            hit_lo   = 1'b1;
        end
    end

    assign out_load = (state_reg == ST_CLAMP) && (!out_valid_reg || result.ready);

    // operand selection for the shared multiply-accumulate unit
    always_comb
    begin
        mac_ctrl.mul_a  = '0;
        mac_ctrl.mul_b  = '0;
        mac_ctrl.acc_op = ACC_HOLD;
        case (state_reg)
            ST_M_DR:
            begin
                mac_ctrl.mul_a = MUL_A_W'(diff_reg);
                mac_ctrl.mul_b = MUL_B_W'(rate_eff);
            end
            ST_M_SMFR:
            begin
                mac_ctrl.mul_a  = MUL_A_W'(fr_reg);
                mac_ctrl.mul_b  = MUL_B_W'(cfg.smoothing);
                mac_ctrl.acc_op = ACC_CLR;
            end
            ST_M_WDR:
            begin
                mac_ctrl.mul_a  = MUL_A_W'(dr_reg);
                mac_ctrl.mul_b  = MUL_B_W'(18'h10000) - MUL_B_W'(cfg.smoothing);
                mac_ctrl.acc_op = ACC_ADD;
            end
            ST_D_ACC:
            begin
                mac_ctrl.acc_op = ACC_ADD;
            end
            ST_M_KP:
            begin
                mac_ctrl.mul_a  = MUL_A_W'(err_reg);
                mac_ctrl.mul_b  = MUL_B_W'(cfg.gain_prop);
                mac_ctrl.acc_op = ACC_CLR;
            end
            ST_M_KD:
            begin
                mac_ctrl.mul_a  = MUL_A_W'(fr_reg);
                mac_ctrl.mul_b  = MUL_B_W'(cfg.gain_deriv);
                mac_ctrl.acc_op = ACC_ADD;
            end
            ST_KD_ADD:
            begin
                mac_ctrl.acc_op = ACC_ADD;
            end
            ST_M_KIL:
            begin
                mac_ctrl.mul_a = MUL_A_W'($unsigned(iq_reg[IQ_LO_W-1:0]));
                mac_ctrl.mul_b = MUL_B_W'(cfg.gain_integ);
            end
            ST_M_KIH:
            begin
                mac_ctrl.mul_a  = MUL_A_W'($signed(iq_reg[IQ_W-1:IQ_LO_W]));
                mac_ctrl.mul_b  = MUL_B_W'(cfg.gain_integ);
                mac_ctrl.acc_op = ACC_ADD;
            end
            ST_KIH_ADD:
            begin
                mac_ctrl.acc_op = ACC_ADD_HI;
            end
            default:
            begin
                mac_ctrl.acc_op = ACC_HOLD;
            end
        endcase
    end

    // sequencer, loop state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ang_reg       <= '0;
            prev_reg      <= '0;
            fr_reg        <= '0;
            es_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_angle_reg <= '0;
            out_deg_reg   <= '0;
            out_up_reg    <= 1'b0;
            out_lo_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_angle_reg <= ang_next;
                out_deg_reg   <= DEG_W'(ang_next >> ANGLE_FRAC_BITS);
                out_up_reg    <= hit_up;
                out_lo_reg    <= hit_lo;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR:      state_reg <= ST_DIFF;
                ST_DIFF:
                begin
                    prev_reg  <= PREV_W'(err_reg);
                    state_reg <= ST_M_DR;
                end
                ST_M_DR:     state_reg <= ST_M_SMFR;
                ST_M_SMFR:   state_reg <= ST_M_WDR;
                ST_M_WDR:    state_reg <= ST_D_ACC;
                ST_D_ACC:    state_reg <= ST_D_FR;
                ST_D_FR:
                begin
                    fr_reg    <= fr_next;
                    state_reg <= ST_M_KP;
                end
                ST_M_KP:     state_reg <= ST_M_KD;
                ST_M_KD:     state_reg <= ST_KD_ADD;
                ST_KD_ADD:   state_reg <= ST_WAIT_DIV;
                ST_WAIT_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_INTEG;
                    end
                end
                ST_INTEG:
                begin
                    es_reg    <= es_next;
                    state_reg <= ST_IQ;
                end
                ST_IQ:       state_reg <= ST_M_KIL;
                ST_M_KIL:    state_reg <= ST_M_KIH;
                ST_M_KIH:    state_reg <= ST_KIH_ADD;
                ST_KIH_ADD:  state_reg <= ST_UPD;
                ST_UPD:      state_reg <= ST_CLAMP;
                ST_CLAMP:
                begin
                    if (out_load)
                    begin
                        ang_reg   <= ang_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    // working registers, loaded at their step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && sample.valid)
        begin
            meas_reg <= sample.measured_angle;
            targ_reg <= sample.beam_angle;
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= err_next;
        end
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= diff_next;
        end
        if (state_reg == ST_M_SMFR)
        begin
            dr_reg <= mac_prod[DR_W-1:0];
        end
        if (state_reg == ST_WAIT_DIV && div_stat.done)
        begin
            inc_reg <= div_stat.quot;
        end
        if (state_reg == ST_IQ)
        begin
            iq_reg <= iq_next;
        end
        if (state_reg == ST_UPD)
        begin
            sum_reg <= sum_next;
        end
    end

    // channel outputs
    assign sample.ready         = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.drive_angle   = out_angle_reg;
    assign result.servo_degrees = out_deg_reg;
    assign result.hit_upper     = out_up_reg;
    assign result.hit_lower     = out_lo_reg;

    // checks
    `IPID_ASSERT_NXT(a_busy_after_accept, clk, rst_n, sample.valid && sample.ready, !sample.ready, "request taken but block still ready")
    `IPID_ASSERT_IMP(a_flags_exclusive, clk, rst_n, result.valid, !(result.hit_upper && result.hit_lower), "both clamp flags set")
    `IPID_ASSERT_IMP(a_div_done_at_integ, clk, rst_n, state_reg == ST_INTEG, div_stat.done, "integral update before divider finished")

endmodule

/* verif/incremental_pid_servo_positioner_core_tb.sv */
// self-checking testbench for the incremental pid servo positioner core
`timescale 1ns / 1ps

module incremental_pid_servo_positioner_core_tb;
    import ipid_pkg::*;

    localparam int     SETTLE_CYCLES = 60;
    localparam int     MAX_PRINTS    = 100;
    localparam int     FRAC          = ANGLE_FRAC_BITS_DEF;
    localparam longint ONE_DEG       = 64'sd256;
    localparam longint IN_MIN        = -64'sd65536;
    localparam longint IN_MAX        = 64'sd65535;
    localparam longint SUM_MAX       = (64'sd1 <<< (SUM_WIDTH_DEF - 1)) - 64'sd1;
    localparam longint SUM_MIN       = -SUM_MAX - 64'sd1;
    localparam longint IQ_CLAMP      = 64'sd1 <<< 45;
    localparam longint FR_MAX        = 64'sd2147483647;
    localparam longint FR_MIN        = -64'sd2147483648;
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef logic [APB_DATA_W-1:0] word_t;

    typedef struct {
        logic signed [IN_W-1:0] measured;
        logic signed [IN_W-1:0] target;
    } angle_req_t;

    typedef struct packed {
        logic [ANG_W-1:0] angle;
        logic [DEG_W-1:0] degrees;
        logic             clamp_hi;
        logic             clamp_lo;
    } servo_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ipid_in_if  sample_ch ();
    ipid_out_if result_ch ();

    incremental_pid_servo_positioner_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and loop state
    cfg_t   cfg_q          = CFG_RESET;
    longint servo_pos      = 0;
    longint last_error     = 0;
    longint rate_filt      = 0;
    longint error_integral = 0;

    angle_req_t    angle_requests[$];
    servo_result_t expected_servo[$];
    int            mismatch_count = 0;
    int            send_idle_pct  = 37;
    int            recv_idle_pct  = 79;

    always #1 clk = ~clk;

    function automatic longint clamp_range(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // one control step: filtered derivative, saturating integral, clamped angle
    function automatic servo_result_t next_servo_result(input logic signed [IN_W-1:0] meas_in,
                                                        input logic signed [IN_W-1:0] targ_in);
        longint meas, targ, rate, sm, err, diff, acc, inc, iq8, upd, ang;
        longint kp, kd, ki, lim_lo, lim_hi;
        servo_result_t res;
        meas   = meas_in;
        targ   = targ_in;
        rate   = cfg_q.loop_rate_hz;
        sm     = cfg_q.smoothing;
        kp     = cfg_q.gain_prop;
        kd     = cfg_q.gain_deriv;
        ki     = cfg_q.gain_integ;
        lim_lo = cfg_q.angle_min;
        lim_hi = cfg_q.angle_max;
        res    = '0;
        // zero rate behaves as one
        if (rate == 0)
        begin
            rate = 1;
        end

        err  = targ - (servo_pos + meas);
        diff = err - last_error;
        acc  = sm * rate_filt + (64'sd65536 - sm) * (diff * rate);
        rate_filt = clamp_range(acc >>> FR_SHIFT, FR_MIN, FR_MAX);

        // integral step truncates toward zero, sum saturates
        inc = (err * (64'sd1 <<< INTEG_EXTRA)) / rate;
        if (inc > 0 && error_integral > SUM_MAX - inc)
        begin
            error_integral = SUM_MAX;
        end
        else if (inc < 0 && error_integral < SUM_MIN - inc)
        begin
            error_integral = SUM_MIN;
        end
        else
        begin
            error_integral = error_integral + inc;
        end
        last_error = err;

        iq8 = clamp_range(error_integral >>> INTEG_EXTRA, -IQ_CLAMP, IQ_CLAMP);
        upd = (kp * err + kd * rate_filt + ki * iq8) >>> UPD_SHIFT;

        // upper test first, so inverted limits favor the maximum
        ang = servo_pos + upd;
        if (ang > lim_hi)
        begin
            ang          = lim_hi;
            res.clamp_hi = 1'b1;
        end
        else if (ang < lim_lo)
        begin
            ang          = lim_lo;
            res.clamp_lo = 1'b1;
        end
        servo_pos   = ang;
        res.angle   = ang[ANG_W-1:0];
        res.degrees = ang[FRAC +: DEG_W];
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
        begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    function automatic longint pick_extreme();
        case ($urandom_range(3))
            0: return IN_MIN;
            1: return IN_MAX;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic word_t pick_gain();
        case ($urandom_range(3))
            0: return $urandom_range(0, 200);
            1: return $urandom_range(0, 1024);
            2: return $urandom_range(1024, 8192);
            default: return $urandom();
        endcase
    endfunction

    task automatic push_req(input longint meas, input longint targ);
        angle_req_t req;
        req.measured = meas[IN_W-1:0];
        req.target   = targ[IN_W-1:0];
        angle_requests.push_back(req);
    endtask

    // apb write: setup cycle, then access cycle with pready tied high
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input word_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_PROP:  cfg_q.gain_prop    = value[GAIN_W-1:0];
            REG_GAIN_DERIV: cfg_q.gain_deriv   = value[GAIN_W-1:0];
            REG_GAIN_INTEG: cfg_q.gain_integ   = value[GAIN_W-1:0];
            REG_LOOP_RATE:  cfg_q.loop_rate_hz = value[RATE_W-1:0];
            REG_SMOOTHING:  cfg_q.smoothing    = value[GAIN_W-1:0];
            REG_ANGLE_MIN:  cfg_q.angle_min    = value[ANG_W-1:0];
            REG_ANGLE_MAX:  cfg_q.angle_max    = value[ANG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (angle_requests.size() != 0 || sample_ch.valid || expected_servo.size() != 0);
    endtask

    // reprogram all registers once the block has gone quiet
    task automatic apply_settings(input word_t gp, input word_t gd, input word_t gi,
                                  input word_t rate, input word_t sm,
                                  input word_t lo_lim, input word_t hi_lim);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_GAIN_PROP, gp);
        write_reg(REG_GAIN_DERIV, gd);
        write_reg(REG_GAIN_INTEG, gi);
        write_reg(REG_LOOP_RATE, rate);
        write_reg(REG_SMOOTHING, sm);
        write_reg(REG_ANGLE_MIN, lo_lim);
        write_reg(REG_ANGLE_MAX, hi_lim);
    endtask

    // mostly tracking runs toward a steady target, some noise and extremes
    task automatic queue_requests(input int count, input bit windup);
        int     run_left;
        int     run_kind;
        longint goal;
        longint housing;
        longint jitter;
        run_left = 0;
        run_kind = 0;
        goal     = 0;
        housing  = 0;
        @(negedge clk);
        for (int n = 0; n < count; n++)
        begin
            if (windup)
            begin
                // drive the integral into positive, then negative saturation
                if (n < count / 4)
                begin
                    push_req(IN_MIN, IN_MAX);
                end
                else
                begin
                    push_req(IN_MAX, IN_MIN);
                end
            end
            else
            begin
                if (run_left == 0)
                begin
                    run_kind = $urandom_range(99);
                    if (run_kind < 70)
                    begin
                        run_left = $urandom_range(8, 24);
                        goal     = $urandom_range(0, 200 * 256);
                        goal     = goal - 10 * ONE_DEG;
                        housing  = $urandom_range(0, 80 * 256);
                        housing  = housing - 40 * ONE_DEG;
                    end
                    else
                    begin
                        run_left = $urandom_range(1, 4);
                    end
                end
                run_left--;
                if (run_kind < 70)
                begin
                    jitter  = $urandom_range(0, 1024);
                    housing = clamp_range(housing + jitter - 512, -60 * ONE_DEG, 60 * ONE_DEG);
                    jitter  = $urandom_range(0, 128);
                    push_req(housing, goal + jitter - 64);
                end
                else if (run_kind < 90)
                begin
                    push_req($urandom(), $urandom());
                end
                else
                begin
                    push_req(pick_extreme(), pick_extreme());
                end
            end
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        angle_req_t req;
        if (!rst_n)
        begin
            sample_ch.valid          <= 1'b0;
            sample_ch.measured_angle <= '0;
            sample_ch.beam_angle     <= '0;
        end
        else if (!sample_ch.valid || sample_ch.ready)
        begin
            if (angle_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = angle_requests.pop_front();
                sample_ch.valid          <= 1'b1;
                sample_ch.measured_angle <= req.measured;
                sample_ch.beam_angle     <= req.target;
            end
            else
            begin
                sample_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor and predictor hookup
    always @(posedge clk)
    begin : watch_results
        servo_result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_servo.size() == 0)
                begin
                    flag_mismatch($sformatf("result angle %0d with no request outstanding",
                                            result_ch.drive_angle));
                end
                else
                begin
                    want = expected_servo.pop_front();
                    if (result_ch.drive_angle !== want.angle)
                    begin
                        flag_mismatch($sformatf("drive_angle got %0d expected %0d",
                                                result_ch.drive_angle, want.angle));
                    end
                    if (result_ch.servo_degrees !== want.degrees)
                    begin
                        flag_mismatch($sformatf("servo_degrees got %0d expected %0d",
                                                result_ch.servo_degrees, want.degrees));
                    end
                    if (result_ch.hit_upper !== want.clamp_hi)
                    begin
                        flag_mismatch($sformatf("hit_upper got %b expected %b",
                                                result_ch.hit_upper, want.clamp_hi));
                    end
                    if (result_ch.hit_lower !== want.clamp_lo)
                    begin
                        flag_mismatch($sformatf("hit_lower got %b expected %b",
                                                result_ch.hit_lower, want.clamp_lo));
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                expected_servo.push_back(next_servo_result(sample_ch.measured_angle,
                                                           sample_ch.beam_angle));
            end
        end
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // stimulus sequence
    initial
    begin : stimulus
        word_t gp, gd, gi, rate, sm, lo_lim, hi_lim, swap;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes at reset settings
        @(negedge clk);
        push_req(0, 0);
        push_req(IN_MIN, IN_MAX);
        push_req(IN_MAX, IN_MIN);
        push_req(IN_MAX, IN_MAX);
        push_req(IN_MIN, IN_MIN);
        push_req(0, 180 * ONE_DEG);
        push_req(0, 180 * ONE_DEG);
        push_req(-1, 0);
        push_req(0, -1);
        push_req(0, 90 * ONE_DEG);
        push_req(5 * ONE_DEG, 90 * ONE_DEG);
        push_req(0, 0);

        // directed: maximum gains, zero loop rate, no smoothing, full range
        apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'd0, 32'd0, 32'd0, 32'hFFFF);
        @(negedge clk);
        push_req(IN_MIN, IN_MAX);
        push_req(IN_MIN, IN_MAX);
        push_req(IN_MAX, IN_MIN);
        push_req(IN_MAX, IN_MIN);
        push_req(0, 0);
        push_req(0, 128 * ONE_DEG);

        // directed: zero gains, top rate, heaviest smoothing, inverted limits
        apply_settings(32'd0, 32'd0, 32'd0, 32'd1000, 32'hFFFF, 32'hFFFF, 32'd0);
        @(negedge clk);
        for (int n = 0; n < 6; n++)
        begin
            push_req(pick_extreme(), $urandom());
        end

        // random part, in phases of settings and idling
        for (int batch = 0; batch < 13; batch++)
        begin
            if (batch == 5)
            begin
                send_idle_pct = 79;
                recv_idle_pct = 37;
            end
            else if (batch == 9)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            gp     = pick_gain();
            gd     = pick_gain();
            gi     = pick_gain();
            sm     = $urandom();
            lo_lim = $urandom_range(0, 30 * 256);
            hi_lim = $urandom_range(90 * 256, 65535);
            case ($urandom_range(9))
                0: rate = 0;
                1: rate = $urandom_range(1001, 1023);
                2: rate = $urandom();
                default: rate = $urandom_range(1, 1000);
            endcase
            case ($urandom_range(9))
                0:
                begin
                    swap   = lo_lim;
                    lo_lim = hi_lim;
                    hi_lim = swap;
                end
                1:
                begin
                    lo_lim = $urandom();
                    hi_lim = $urandom();
                end
                default: ;
            endcase
            case (batch)
                0:
                begin
                    gp = 2048; gd = 200; gi = 100; rate = 100;
                    sm = 49152; lo_lim = 10 * 256; hi_lim = 160 * 256;
                end
                1:
                begin
                    // upper bits ignored, rate above the nominal range
                    gp = 32'hABCD_1000; gd = 41; gi = 41; rate = 32'hFFFF_FFFF;
                    sm = 32'hFFFF_0000 | $urandom_range(0, 65535); lo_lim = 0; hi_lim = 46080;
                end
                2:
                begin
                    gp = 1024; gd = 0; gi = 4096; rate = 0;
                    sm = 32768; lo_lim = 0; hi_lim = 32'hFFFF;
                end
                12:
                begin
                    gp = CFG_RESET.gain_prop; gd = CFG_RESET.gain_deriv;
                    gi = CFG_RESET.gain_integ; rate = CFG_RESET.loop_rate_hz;
                    sm = CFG_RESET.smoothing; lo_lim = CFG_RESET.angle_min;
                    hi_lim = CFG_RESET.angle_max;
                end
                default: ;
            endcase
            apply_settings(gp, gd, gi, rate, sm, lo_lim, hi_lim);
            if (batch == 1)
            begin
                // write to an unmapped register index must change nothing
                write_reg(REG_SPARE, $urandom());
            end
            queue_requests((batch == 2) ? 140 : 55, batch == 2);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #1_000_000;
        $display("timeout waiting for servo results");
        $display("== FAIL ==");
        $finish;
    end

endmodule
